FILE: rtl/core/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package shs_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  byte_count;
		logic        end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} out_item_t;

	// One packed block word handed from the front to the compression engine.
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} blk_word_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [3:0] LenHiIdx = 4'd14;
	localparam logic [3:0] LenLoIdx = 4'd15;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: rtl/core/shs_front.sv
// Front end: packs message bytes into block words and generates the padding.
module shs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  shs_pkg::in_item_t   item,
	input  shs_pkg::q_stat_t    q_stat,
	output logic                q_push,
	output shs_pkg::blk_word_t  q_data
);

	typedef enum logic {ST_IDLE, ST_PAD} state_t;

	state_t       state_q;
	logic [31:0]  partial_q;
	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic         first_q;
	logic         hi_done_q;

	logic [2:0]   cnt;
	logic [1:0]   pos;
	logic [3:0]   widx;
	logic [31:0]  mask;
	logic [63:0]  shifted;
	logic [63:0]  combined;
	logic [2:0]   span;
	logic [63:0]  bits;
	logic         accept;
	logic [31:0]  pad_word;
	logic         pad_last;

	assign pos  = fill_q[1:0];
	assign widx = fill_q[5:2];
	assign cnt  = (item.byte_count > 3'd4) ? 3'd4 : item.byte_count;
	assign mask = (cnt == 3'd0) ? 32'h0 : ~(32'hFFFF_FFFF >> {cnt, 3'b000});
	assign shifted  = {item.message_word & mask, 32'h0} >> {pos, 3'b000};
	assign combined = {partial_q, 32'h0} | shifted;
	assign span     = {1'b0, pos} + cnt;
	assign bits     = {len_q, 3'b000};

	assign full   = (state_q != ST_IDLE) || q_stat.full;
	assign accept = push && !full;

	always_comb begin
		pad_last = 1'b0;
		priority if (!first_q) begin
			pad_word = partial_q | ({shs_pkg::PadMark, 24'h0} >> {pos, 3'b000});
		end else if (widx == shs_pkg::LenHiIdx) begin
			pad_word = bits[63:32];
		end else if (widx == shs_pkg::LenLoIdx && hi_done_q) begin
			pad_word = bits[31:0];
			pad_last = 1'b1;
		end else begin
			pad_word = 32'h0;
		end
	end

	always_comb begin
		q_push = 1'b0;
		q_data = '{word: combined[63:32], last: 1'b0};
		if (state_q == ST_IDLE) begin
			q_push = accept && (span >= 3'd4);
		end else begin
			q_push = !q_stat.full;
			q_data = '{word: pad_word, last: pad_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			partial_q <= '0;
			fill_q    <= '0;
			len_q     <= '0;
			first_q   <= 1'b0;
			hi_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						partial_q <= (span >= 3'd4) ? combined[31:0] : combined[63:32];
						fill_q    <= fill_q + {3'b000, cnt};
						len_q     <= len_q + {58'h0, cnt};
						if (item.end_of_message) begin
							state_q   <= ST_PAD;
							first_q   <= 1'b0;
							hi_done_q <= 1'b0;
						end
					end
				end
				ST_PAD: begin
					if (!q_stat.full) begin
						fill_q  <= {widx + 4'd1, 2'b00};
						first_q <= 1'b1;
						if (first_q && widx == shs_pkg::LenHiIdx) begin
							hi_done_q <= 1'b1;
						end
						if (pad_last) begin
							// message done: drop length and return to packing
							state_q   <= ST_IDLE;
							partial_q <= '0;
							fill_q    <= '0;
							len_q     <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/shs_fifo.sv
// Short word queue between the packing front and the compression engine.
module shs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  shs_pkg::blk_word_t  wdata,
	input  logic                rd,
	output shs_pkg::blk_word_t  rdata,
	output shs_pkg::q_stat_t    stat
);

	shs_pkg::blk_word_t            mem_q [shs_pkg::QDepth];
	logic [shs_pkg::QPtrW-1:0]     wptr_q;
	logic [shs_pkg::QPtrW-1:0]     rptr_q;
	logic [shs_pkg::QPtrW:0]       count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign stat.full  = (count_q == (shs_pkg::QPtrW+1)'(shs_pkg::QDepth));
	assign stat.empty = (count_q == '0);
	assign do_wr = wr && !stat.full;
	assign do_rd = rd && !stat.empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + {{shs_pkg::QPtrW{1'b0}}, do_wr}
				- {{shs_pkg::QPtrW{1'b0}}, do_rd};
		end
	end

endmodule

FILE: rtl/core/shs_core.sv
// Back end: 64-round compression, one round per cycle, and digest readout.
module shs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  shs_pkg::q_stat_t    q_stat,
	input  shs_pkg::blk_word_t  q_data,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output shs_pkg::out_item_t  result
);

	typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_ADD, ST_OUT} state_t;

	state_t       state_q;
	logic [31:0]  win_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];
	logic [3:0]   cnt_q;
	logic [5:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic         blk_last_q;

	logic [31:0]  ch;
	logic [31:0]  mj;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  w_new;

	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + shs_pkg::big_sig1(v_q[4]) + ch + shs_pkg::RoundK[rnd_q] + win_q[0];
	assign t2 = shs_pkg::big_sig0(v_q[0]) + mj;
	assign w_new = win_q[0] + shs_pkg::small_sig0(win_q[1]) + win_q[9]
		+ shs_pkg::small_sig1(win_q[14]);

	assign q_pop = (state_q == ST_LOAD) && !q_stat.empty;
	assign empty = (state_q != ST_OUT);
	assign result = '{digest_word: h_q[oidx_q], word_index: oidx_q,
		final_word: (oidx_q == 3'd7)};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= q_data.word;
		end else if (state_q == ST_RUN) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w_new;
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == ST_RUN) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			rnd_q      <= '0;
			oidx_q     <= '0;
			blk_last_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= shs_pkg::InitH[i];
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						blk_last_q <= q_data.last;
						cnt_q      <= cnt_q + 4'd1;
						if (cnt_q == 4'd15) begin
							state_q <= ST_RUN;
							rnd_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q  <= '0;
					state_q <= blk_last_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= shs_pkg::InitH[i];
							blk_last_q <= 1'b0;
							state_q    <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

FILE: rtl/core/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: packing front, word queue, compression back.
//
//  channel   direction  handshake           payload
//  item      in         push / full         message_word, byte_count, end_of_message
//  result    out        pop / empty         digest_word, word_index, final_word
//
// Flow: the back end loads a block of 16 words from the queue, runs 64 rounds
// (one per cycle) and then folds the working variables into the hash.
// The front packs at most one word per cycle and pads at one word per cycle while the queue is not full.
// Reset: arst_n clears all control state and loads the initial hash values.
// Stalls: the 4-word queue lets the front keep taking transactions, until it fills, while the
// back end compresses or waits for the eight digest transactions to be popped.
module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  shs_pkg::in_item_t   item,
	output logic                empty,
	input  logic                pop,
	output shs_pkg::out_item_t  result
);

	shs_pkg::q_stat_t    q_stat;
	shs_pkg::blk_word_t  q_wdata;
	shs_pkg::blk_word_t  q_rdata;
	logic                q_push;
	logic                q_pop;

	// Pack bytes into words and append padding and bit length.
	shs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// Decouple the two halves.
	shs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// Compress each block; after a block tagged last, hold the digest for readout.
	shs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (q_rdata),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// The final digest word is always index seven.
	a_final_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.final_word == (result.word_index == 3'd7)))
		else $error("final_word does not match word_index");

	// Popping the last digest word ends the readout.
	a_end_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.final_word) |=> empty)
		else $error("digest readout continued past word seven");

	// A full queue must push back on the input side.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> full)
		else $error("input accepted while word queue is full");

	// Readout advances one index per popped transaction.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.final_word) |=>
		(!empty && result.word_index == $past(result.word_index) + 3'd1))
		else $error("digest word index skipped");

endmodule
